@@ rtl/lsms_pkg.sv @@
// Package: types, mode and aim codes for the launcher supervisory mode sequencer.
package lsms_pkg;

  localparam logic [2:0] MODE_OFFLINE     = 3'd0;
  localparam logic [2:0] MODE_ERROR       = 3'd1;
  localparam logic [2:0] MODE_DEBUG       = 3'd2;
  localparam logic [2:0] MODE_CHECKING    = 3'd3;
  localparam logic [2:0] MODE_CALIBRATING = 3'd4;
  localparam logic [2:0] MODE_STANDBY     = 3'd5;
  localparam logic [2:0] MODE_AUTO_PREP   = 3'd6;
  localparam logic [2:0] MODE_AUTO_FIRE   = 3'd7;

  localparam logic [1:0] AIM_MANUAL  = 2'd0;
  localparam logic [1:0] AIM_CORRECT = 2'd1;
  localparam logic [1:0] AIM_VISION  = 2'd2;
  localparam logic [1:0] AIM_CAL     = 2'd3;

  localparam logic [1:0] SW_UP     = 2'd0;
  localparam logic [1:0] SW_MIDDLE = 2'd1;
  localparam logic [1:0] SW_DOWN   = 2'd2;

  typedef enum logic [7:0] {
    ST_OFFLINE     = 8'b0000_0001,
    ST_ERROR       = 8'b0000_0010,
    ST_DEBUG       = 8'b0000_0100,
    ST_CHECKING    = 8'b0000_1000,
    ST_CALIBRATING = 8'b0001_0000,
    ST_STANDBY     = 8'b0010_0000,
    ST_AUTO_PREP   = 8'b0100_0000,
    ST_AUTO_FIRE   = 8'b1000_0000
  } sup_state_t;

  typedef struct packed {
    sup_state_t mode;
    logic [1:0] aim;
    logic       enable;
    logic       skip;
    logic       auto_on;
    logic       override;
    logic       calibrated;
    logic       check;
  } seq_state_t;

  typedef struct packed {
    logic       link_ok;
    logic [1:0] left_switch;
    logic [1:0] right_switch;
    logic       limit_hit;
    logic       keys_all_checked;
    logic       yaw_calibrated;
    logic       launcher_calibrated;
    logic       deliver_at_target;
    logic       igniter_at_target;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] aim_mode;
    logic       motors_on;
    logic       manual_jog;
    logic       force_checks_passed;
    logic       clear_check_progress;
    logic       cal_begin;
    logic       zero_yaw_target;
    logic       reset_fire_sequence;
    logic       igniter_to_aim_height;
    logic       run_fire_sequence;
    logic       checks_ok;
  } out_item_t;

  function automatic logic [2:0] mode_code(input sup_state_t s);
    logic [2:0] c;
    c = MODE_OFFLINE;
    unique case (s)
      ST_OFFLINE:     c = MODE_OFFLINE;
      ST_ERROR:       c = MODE_ERROR;
      ST_DEBUG:       c = MODE_DEBUG;
      ST_CHECKING:    c = MODE_CHECKING;
      ST_CALIBRATING: c = MODE_CALIBRATING;
      ST_STANDBY:     c = MODE_STANDBY;
      ST_AUTO_PREP:   c = MODE_AUTO_PREP;
      ST_AUTO_FIRE:   c = MODE_AUTO_FIRE;
      default:        c = MODE_OFFLINE;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/lsms_step.sv @@
// Per-tick next-state and result logic of the supervisory mode sequencer.
module lsms_step
  import lsms_pkg::*;
(
  input  seq_state_t st_i,
  input  in_item_t   item_i,
  input  logic       debug_en_i,
  output seq_state_t st_o,
  output out_item_t  res_o
);

  seq_state_t s;
  logic       p_force;
  logic       p_clear;
  logic       p_start;
  logic       p_zero;
  logic       p_rst_fire;
  logic       p_aim_h;
  logic       p_run;
  logic       mot;

  always_comb begin
    s          = st_i;
    p_force    = 1'b0;
    p_clear    = 1'b0;
    p_start    = 1'b0;
    p_zero     = 1'b0;
    p_rst_fire = 1'b0;
    p_aim_h    = 1'b0;
    p_run      = 1'b0;

    if (!item_i.link_ok) begin
      s.mode = ST_OFFLINE;
    end else begin
      if (debug_en_i && st_i.calibrated) begin
        s.mode = ST_DEBUG;
      end else if (st_i.mode == ST_DEBUG && !st_i.enable) begin
        p_clear = 1'b1;
        s.mode  = ST_CHECKING;
      end
      s.enable = (item_i.left_switch != SW_UP);
      if (item_i.left_switch == SW_DOWN) begin
        s.skip    = 1'b1;
        s.auto_on = 1'b1;
      end else if (item_i.left_switch == SW_MIDDLE) begin
        s.skip    = 1'b0;
        s.auto_on = 1'b0;
      end
      if (item_i.right_switch == SW_UP) begin
        s.override = 1'b1;
      end else if (item_i.right_switch == SW_MIDDLE) begin
        s.override = 1'b0;
        s.aim      = AIM_CORRECT;
      end else begin
        s.override = 1'b0;
        s.aim      = AIM_VISION;
      end
    end

    if (s.mode != ST_CALIBRATING && item_i.limit_hit) begin
      s.mode = ST_ERROR;
    end

    unique case (s.mode)
      ST_ERROR: begin
        if (item_i.link_ok && !s.enable) s.mode = ST_CHECKING;
      end
      ST_OFFLINE: begin
        if (item_i.link_ok) s.mode = ST_CHECKING;
      end
      ST_CHECKING: begin
        p_force = s.skip;
        s.check = s.skip || item_i.keys_all_checked;
        if (s.check) begin
          s.mode  = ST_CALIBRATING;
          p_start = 1'b1;
        end
      end
      ST_CALIBRATING: begin
        s.aim = AIM_CAL;
        if (item_i.yaw_calibrated) begin
          s.aim  = AIM_MANUAL;
          p_zero = 1'b1;
        end
        s.calibrated = item_i.yaw_calibrated && item_i.launcher_calibrated;
        if (s.calibrated) s.mode = ST_STANDBY;
      end
      ST_STANDBY: begin
        if (s.auto_on) begin
          p_rst_fire = 1'b1;
          s.mode     = ST_AUTO_PREP;
        end
      end
      ST_AUTO_PREP: begin
        p_aim_h = 1'b1;
        if (item_i.deliver_at_target && item_i.igniter_at_target) s.mode = ST_AUTO_FIRE;
        if (!s.auto_on) s.mode = ST_STANDBY;
      end
      ST_AUTO_FIRE: begin
        p_run = 1'b1;
        if (!s.auto_on) s.mode = ST_STANDBY;
      end
      ST_DEBUG: begin
      end
      default: begin
      end
    endcase

    mot = s.enable && !(s.mode == ST_OFFLINE || s.mode == ST_CHECKING ||
                        s.mode == ST_ERROR);
  end

  assign st_o = s;

  always_comb begin
    res_o.mode                  = mode_code(s.mode);
    res_o.aim_mode              = s.aim;
    res_o.motors_on             = mot;
    res_o.manual_jog            = s.override && item_i.link_ok;
    res_o.force_checks_passed   = p_force;
    res_o.clear_check_progress  = p_clear;
    res_o.cal_begin             = p_start;
    res_o.zero_yaw_target       = p_zero;
    res_o.reset_fire_sequence   = p_rst_fire;
    res_o.igniter_to_aim_height = p_aim_h;
    res_o.run_fire_sequence     = p_run;
    res_o.checks_ok             = s.check;
  end

endmodule

@@ rtl/launcher_supervisory_mode_sequencer.sv @@
// Top level of the launcher supervisory mode sequencer: item registers and mode state.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | in_item (in_item_t)
//   out_    | output    | out_valid / out_stall| out_item (out_item_t)
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_data (debug enable)
//
// One item per cycle sustained while out_stall is low.
// The mode update runs between the input register and the result register.
// Synchronous active-low reset puts the mode in checking with all latches clear.
// An output stall holds the result; the input register then stalls in turn.
// cfg_ready is always high.
module launcher_supervisory_mode_sequencer
  import lsms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  logic       debug_en_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_item_t  res_nxt;
  logic       advance;

  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  lsms_step u_step (
    .st_i      (st_r),
    .item_i    (in_item_r),
    .debug_en_i(debug_en_r),
    .st_o      (st_nxt),
    .res_o     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      debug_en_r <= 1'b0;
      st_r       <= '{mode: ST_CHECKING, aim: AIM_MANUAL, default: 1'b0};
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) debug_en_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
    if (advance) out_item_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(out_item_r))
    else $error("stalled result changed");

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result lost after advance");

  a_no_motor_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_item_r.mode == MODE_CHECKING || out_item_r.mode == MODE_OFFLINE ||
                  out_item_r.mode == MODE_ERROR) |-> !out_item_r.motors_on)
    else $error("motors on in a safe mode");

  a_start_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.cal_begin |-> out_item_r.mode == MODE_CALIBRATING)
    else $error("calibration start outside calibrating");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the launcher supervisory mode sequencer.
module tb;
  import lsms_pkg::*;

  class tick_scoreboard;
    logic [2:0] mode_r;
    logic [1:0] aim_r;
    logic       enable_r;
    logic       skip_r;
    logic       auto_r;
    logic       override_r;
    logic       calibrated_r;
    logic       check_r;
    logic       debug_en;
    out_item_t  expected_outs[$];
    int         errors;
    int         ticks;
    int         results;
    logic [7:0] modes_seen;

    function void reset_state();
      mode_r       = MODE_CHECKING;
      aim_r        = AIM_MANUAL;
      enable_r     = 1'b0;
      skip_r       = 1'b0;
      auto_r       = 1'b0;
      override_r   = 1'b0;
      calibrated_r = 1'b0;
      check_r      = 1'b0;
      debug_en     = 1'b0;
      errors       = 0;
      ticks        = 0;
      results      = 0;
      modes_seen   = '0;
    endfunction

    function out_item_t predict_tick(in_item_t t);
      out_item_t r;
      r = '0;
      if (!t.link_ok) begin
        mode_r = MODE_OFFLINE;
      end else begin
        if (debug_en && calibrated_r) begin
          mode_r = MODE_DEBUG;
        end else if (mode_r == MODE_DEBUG && !enable_r) begin
          r.clear_check_progress = 1'b1;
          mode_r = MODE_CHECKING;
        end
        enable_r = (t.left_switch != SW_UP);
        if (t.left_switch == SW_DOWN) begin
          skip_r = 1'b1;
          auto_r = 1'b1;
        end else if (t.left_switch == SW_MIDDLE) begin
          skip_r = 1'b0;
          auto_r = 1'b0;
        end
        if (t.right_switch == SW_UP) begin
          override_r = 1'b1;
        end else begin
          override_r = 1'b0;
          aim_r = (t.right_switch == SW_MIDDLE) ? AIM_CORRECT : AIM_VISION;
        end
      end
      if (mode_r != MODE_CALIBRATING && t.limit_hit) mode_r = MODE_ERROR;
      case (mode_r)
        MODE_ERROR: begin
          if (t.link_ok && !enable_r) mode_r = MODE_CHECKING;
        end
        MODE_OFFLINE: begin
          if (t.link_ok) mode_r = MODE_CHECKING;
        end
        MODE_CHECKING: begin
          r.force_checks_passed = skip_r;
          check_r = skip_r || t.keys_all_checked;
          if (check_r) begin
            mode_r = MODE_CALIBRATING;
            r.cal_begin = 1'b1;
          end
        end
        MODE_CALIBRATING: begin
          aim_r = AIM_CAL;
          if (t.yaw_calibrated) begin
            aim_r = AIM_MANUAL;
            r.zero_yaw_target = 1'b1;
          end
          calibrated_r = t.yaw_calibrated && t.launcher_calibrated;
          if (calibrated_r) mode_r = MODE_STANDBY;
        end
        MODE_STANDBY: begin
          if (auto_r) begin
            r.reset_fire_sequence = 1'b1;
            mode_r = MODE_AUTO_PREP;
          end
        end
        MODE_AUTO_PREP: begin
          r.igniter_to_aim_height = 1'b1;
          if (t.deliver_at_target && t.igniter_at_target) mode_r = MODE_AUTO_FIRE;
          if (!auto_r) mode_r = MODE_STANDBY;
        end
        MODE_AUTO_FIRE: begin
          r.run_fire_sequence = 1'b1;
          if (!auto_r) mode_r = MODE_STANDBY;
        end
        default: begin
        end
      endcase
      r.mode       = mode_r;
      r.aim_mode   = aim_r;
      r.motors_on  = (mode_r != MODE_OFFLINE) && (mode_r != MODE_CHECKING) &&
                     (mode_r != MODE_ERROR) && enable_r;
      r.manual_jog = override_r && t.link_ok;
      r.checks_ok  = check_r;
      return r;
    endfunction

    function void note_tick(in_item_t t);
      ticks++;
      expected_outs.push_back(predict_tick(t));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (expected_outs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result item %h", got);
        return;
      end
      want = expected_outs.pop_front();
      modes_seen[want.mode] = 1'b1;
      if (got.mode !== want.mode || got.aim_mode !== want.aim_mode ||
          got.motors_on !== want.motors_on || got.manual_jog !== want.manual_jog ||
          got.force_checks_passed !== want.force_checks_passed ||
          got.clear_check_progress !== want.clear_check_progress ||
          got.cal_begin !== want.cal_begin ||
          got.zero_yaw_target !== want.zero_yaw_target ||
          got.reset_fire_sequence !== want.reset_fire_sequence ||
          got.igniter_to_aim_height !== want.igniter_to_aim_height ||
          got.run_fire_sequence !== want.run_fire_sequence ||
          got.checks_ok !== want.checks_ok) begin
        errors++;
        if (errors <= 10)
          $display("Result %0d: expected mode %0d aim %0d flags %b, got %0d %0d %b",
                   results, want.mode, want.aim_mode, want[9:0],
                   got.mode, got.aim_mode, got[9:0]);
      end
    endfunction

    function int pending();
      return expected_outs.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  tick_scoreboard sb;
  bit         idle_on = 1'b1;
  int         hold_req = 0;
  int         stall_run = 0;
  logic       link_cur = 1'b1;
  logic [1:0] left_cur = SW_MIDDLE;
  logic [1:0] right_cur = SW_UP;

  launcher_supervisory_mode_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int rand_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t mk(logic link, logic [1:0] left, logic [1:0] right,
                                  logic limit, logic keys, logic yaw, logic lau,
                                  logic del, logic ign);
    in_item_t t;
    t.link_ok             = link;
    t.left_switch         = left;
    t.right_switch        = right;
    t.limit_hit           = limit;
    t.keys_all_checked    = keys;
    t.yaw_calibrated      = yaw;
    t.launcher_calibrated = lau;
    t.deliver_at_target   = del;
    t.igniter_at_target   = ign;
    return t;
  endfunction

  // Switches and link are held for stretches, like an operator would.
  function automatic in_item_t next_tick();
    int r;
    if (link_cur && $urandom_range(0, 99) < 2) link_cur = 1'b0;
    else if (!link_cur && $urandom_range(0, 99) < 25) link_cur = 1'b1;
    if ($urandom_range(0, 99) < 8) begin
      r = $urandom_range(0, 99);
      left_cur = (r < 15) ? SW_UP : (r < 45) ? SW_MIDDLE : (r < 90) ? SW_DOWN : 2'd3;
    end
    if ($urandom_range(0, 99) < 8) right_cur = 2'($urandom_range(0, 3));
    return mk(link_cur, left_cur, right_cur, $urandom_range(0, 99) < 2,
              $urandom_range(0, 99) < 25, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)),
              $urandom_range(0, 99) < 60, $urandom_range(0, 99) < 60);
  endfunction

  task automatic send_tick(in_item_t t, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debug_enable(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.debug_en = v;
    cfg_valid <= 1'b0;
  endtask

  // result side: sample at the edge, then pick the next stall value
  initial begin
    int r;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (hold_req > 0) begin
        hold_req--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_stall <= 1'b0;
        end else begin
          stall_run = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    in_item_t   dir_a[$];
    in_item_t   dir_b[$];
    in_item_t   dir_c[$];
    logic       settings[6];
    int         nmodes;
    sb = new();
    sb.reset_state();
    settings = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // link down, limit in checking, error hold and release, full bring-up to auto fire
    dir_a = '{mk(1'b0, SW_UP, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_UP, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_UP, SW_UP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_MIDDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_UP, SW_MIDDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_MIDDLE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_DOWN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_MIDDLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_MIDDLE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0),
              mk(1'b1, 2'd3, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_DOWN, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_DOWN, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0),
              mk(1'b1, SW_DOWN, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1),
              mk(1'b1, 2'd3, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1),
              mk(1'b0, SW_DOWN, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_DOWN, SW_MIDDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, 2'd3, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1),
              mk(1'b1, SW_DOWN, SW_UP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)};
    // debug entry, limit in debug, then debug entry again
    dir_b = '{mk(1'b1, SW_UP, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_UP, SW_UP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_UP, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)};
    dir_c = '{mk(1'b1, SW_MIDDLE, SW_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_UP, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
              mk(1'b1, SW_MIDDLE, SW_UP, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0)};

    foreach (dir_a[i]) send_tick(dir_a[i], rand_gap());
    pause_until_drained();
    write_debug_enable(1'b1);
    foreach (dir_b[i]) send_tick(dir_b[i], rand_gap());
    pause_until_drained();
    write_debug_enable(1'b0);
    foreach (dir_c[i]) send_tick(dir_c[i], rand_gap());
    pause_until_drained();

    for (int p = 0; p < 6; p++) begin
      write_debug_enable(settings[p]);
      for (int i = 0; i < 255; i++) begin
        if (i % 50 == 0) idle_on = ($urandom_range(0, 9) >= 3);
        if (p == 1 && i == 100) hold_req = 300;
        if (p == 3 && i == 120) pause_until_drained();
        send_tick(next_tick(), rand_gap());
      end
      pause_until_drained();
    end

    repeat (10) @(posedge clk);
    sb.errors += sb.pending();
    nmodes = $countones(sb.modes_seen);
    $display("Drove %0d control ticks through both debug settings, %0d results checked.",
             sb.ticks, sb.results);
    $display("%0d of 8 supervisory modes reached, with random stalls on both sides.", nmodes);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lsms_pkg.sv
rtl/lsms_step.sv
rtl/launcher_supervisory_mode_sequencer.sv
test/tb.sv
